// ===== rtl/core/brlcg_pkg.sv =====
// shared types and constants of the bounded random lcg unit
// no dependencies; imported by bounded_random_lcg_unit
`default_nettype none

package brlcg_pkg;

   localparam int SeedWidth  = 16;
   localparam int BoundWidth = 15;
   localparam int DrawWidth  = 15;
   localparam int StateWidth = 32;
   localparam int DrawShift  = 16;
   localparam int CountWidth = $clog2(DrawWidth);

   localparam logic [StateWidth-1:0] LcgMul = 32'd214013;
   localparam logic [StateWidth-1:0] LcgAdd = 32'd2531011;

   // request tdata: timer_seed, lower_bound, upper_bound, zero fill
   localparam int ReqDataWidth = ((SeedWidth + 2 * BoundWidth + 7) / 8) * 8;
   // response tdata: random_value, zero fill
   localparam int RspDataWidth = ((DrawWidth + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIVIDE,
      ST_CHECK,
      ST_EMIT
   } brlcg_state_type;

endpackage : brlcg_pkg

`default_nettype wire

// ===== rtl/core/bounded_random_lcg_unit.sv =====
// bounded pseudorandom value generator: lcg step plus rejection on a modulo
// one sequencer drives a multiplier step and a bit-serial remainder unit
// depends on brlcg_pkg
//
// usage:
//   req channel carries one item: a timer count loaded as the generator seed,
//   an inclusive lower bound and an exclusive upper bound. rsp channel returns
//   one item per request: the accepted value in tdata and a range error flag
//   in tuser (value zero when the flag is set).
// timing:
//   each try runs the lcg multiply-add in ST_STEP, then the one-bit-per-cycle
//   restoring remainder unit in ST_DIVIDE over every draw bit, then the lower
//   bound compare in ST_CHECK, which emits the value or starts a new try; the
//   number of tries depends on the data. an empty range skips the tries and
//   goes straight to ST_EMIT.
//   req_tready is high only while the sequencer is idle; one request at a time.
// stalls and reset:
//   a finished result sits in the output register until taken; a new request
//   can be accepted meanwhile, and its result waits until the register frees.
//   reset is synchronous; it empties the output register, returns the
//   sequencer to idle and clears the generator seed.
`default_nettype none

module bounded_random_lcg_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] timer_seed, [30:16] lower_bound, [45:31] upper_bound, rest zero
   input  wire logic [brlcg_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [14:0] random_value, rest zero
   output logic [brlcg_pkg::RspDataWidth-1:0]     rsp_tdata,
   // [0] range_error
   output logic                                   rsp_tuser
);
   import brlcg_pkg::*;

   brlcg_state_type        state_ff, state_in;
   logic [StateWidth-1:0]  seed_ff, seed_in;
   logic [BoundWidth-1:0]  lo_ff, lo_in;
   logic [BoundWidth-1:0]  hi_ff, hi_in;
   logic [DrawWidth-1:0]   draw_ff, draw_in;
   logic [BoundWidth-1:0]  rem_ff, rem_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DrawWidth-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic [StateWidth-1:0]  lcg_next;
   logic [BoundWidth:0]    trial;
   logic                   trial_ge;
   logic                   out_free;
   logic [SeedWidth-1:0]   req_seed;
   logic [BoundWidth-1:0]  req_lo;
   logic [BoundWidth-1:0]  req_hi;

   assign req_seed = req_tdata[SeedWidth-1:0];
   assign req_lo   = req_tdata[SeedWidth +: BoundWidth];
   assign req_hi   = req_tdata[SeedWidth + BoundWidth +: BoundWidth];

   assign lcg_next = StateWidth'(seed_ff * LcgMul + LcgAdd);
   assign trial    = {rem_ff, draw_ff[DrawWidth-1]};
   assign trial_ge = trial >= {1'b0, hi_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_value_ff);
   assign rsp_tuser  = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      draw_ff      <= draw_in;
      rem_ff       <= rem_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      draw_in      = draw_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               seed_in = StateWidth'(req_seed);
               lo_in   = req_lo;
               hi_in   = req_hi;
               rem_in  = '0;
               // empty range skips the search
               if (req_hi == '0 || req_hi <= req_lo) begin
                  err_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            seed_in  = lcg_next;
            draw_in  = lcg_next[DrawShift +: DrawWidth];
            rem_in   = '0;
            count_in = CountWidth'(DrawWidth - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // restoring remainder, one draw bit per cycle, msb first
            rem_in  = trial_ge ? BoundWidth'(trial - {1'b0, hi_ff})
                               : trial[BoundWidth-1:0];
            draw_in = {draw_ff[DrawWidth-2:0], 1'b0};
            if (count_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_CHECK: begin
            state_in = (rem_ff >= lo_ff) ? ST_EMIT : ST_STEP;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = err_ff ? '0 : rem_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_value_ff == '0)
      else $error("range error item carries a nonzero value");

   a_rem_below_hi: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < hi_ff)
      else $error("partial remainder not below the modulus");

   a_value_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && !err_ff |=>
         rsp_value_ff >= $past(lo_ff) && rsp_value_ff < $past(hi_ff))
      else $error("emitted value outside the requested range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after accepting an item");

   a_emit_keeps_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("pending result lost or overwritten");
`endif

endmodule : bounded_random_lcg_unit

`default_nettype wire
